/* sv/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    // width of the converted binary value
    localparam int VALUE_BITS = 64;

    // decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * DIGITS;

    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

    localparam int CHAR_W     = 6;
    // ascii '0' kept to six bits
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

    // finished bcd word handed from the converter to the digit emitter
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } t_bcd_xfer;

endpackage

/* sv/b2da_dabble.sv */
// ----------------------------------------------------------------------------
// b2da_dabble
// Bit-serial double dabble: one input bit is shifted into the bcd register
// per cycle, with add-3 correction on every digit before the shift.
// ----------------------------------------------------------------------------
module b2da_dabble (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [b2da_pkg::VALUE_BITS-1:0]    i_value,
    output b2da_pkg::t_bcd_xfer                o_xfer,
    input  logic                               i_xfer_take
);

    logic                               r_busy;
    logic                               r_full;
    logic [b2da_pkg::BIT_CNT_W-1:0]     r_cnt;
    logic [b2da_pkg::VALUE_BITS-1:0]    r_bin;
    logic [b2da_pkg::BCD_W-1:0]         r_bcd;

    logic [b2da_pkg::BCD_W-1:0]         n_bcd;
    logic [b2da_pkg::BCD_W-1:0]         w_adj;
    logic                               w_accept;

    assign o_stall  = r_busy | r_full;
    assign w_accept = i_valid & ~o_stall;

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
        n_bcd = {w_adj[b2da_pkg::BCD_W-2:0], r_bin[b2da_pkg::VALUE_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_cnt  <= b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - b2da_pkg::BIT_CNT_W'(1);
                if (r_cnt == b2da_pkg::BIT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_full <= 1'b1;
                end
            end else if (r_full && i_xfer_take) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[b2da_pkg::VALUE_BITS-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_xfer.valid = r_full;
    assign o_xfer.bcd   = r_bcd;

endmodule

/* sv/b2da_emit.sv */
// ----------------------------------------------------------------------------
// b2da_emit
// Digit emitter: shifts the bcd word out one digit per cycle unless stalled,
// most significant first, skipping leading zeros, into a registered output.
// ----------------------------------------------------------------------------
module b2da_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  b2da_pkg::t_bcd_xfer                i_xfer,
    output logic                               o_xfer_take,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                               o_last_digit
);

    logic                               r_busy;
    logic                               r_started;
    logic [b2da_pkg::DIG_CNT_W-1:0]     r_rem;
    logic [b2da_pkg::BCD_W-1:0]         r_digits;
    logic                               r_valid;
    logic [b2da_pkg::CHAR_W-1:0]        r_char;
    logic                               r_last;

    logic [3:0]                         w_top;
    logic                               w_is_last;
    logic                               w_emit;
    logic                               w_step;
    logic                               w_taken;
    logic                               n_valid;

    assign w_top       = r_digits[b2da_pkg::BCD_W-1 -: 4];
    assign w_is_last   = (r_rem == b2da_pkg::DIG_CNT_W'(1));
    // leading zeros are dropped, but the units digit always goes out
    assign w_emit      = r_started | (w_top != 4'd0) | w_is_last;
    assign w_taken     = r_valid & ~i_stall;
    assign w_step      = r_busy & (~r_valid | ~i_stall);
    assign o_xfer_take = ~r_busy & i_xfer.valid;

    always_comb begin
        n_valid = r_valid;
        if (w_taken) begin
            n_valid = 1'b0;
        end
        if (w_step && w_emit) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_started <= 1'b0;
            r_rem     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_xfer_take) begin
                r_busy    <= 1'b1;
                r_started <= 1'b0;
                r_rem     <= b2da_pkg::DIG_CNT_W'(b2da_pkg::DIGITS);
            end else if (w_step) begin
                r_rem     <= r_rem - b2da_pkg::DIG_CNT_W'(1);
                r_started <= r_started | w_emit;
                if (w_is_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_xfer_take) begin
            r_digits <= i_xfer.bcd;
        end else if (w_step) begin
            r_digits <= {r_digits[b2da_pkg::BCD_W-5:0], 4'd0};
        end
        if (w_step && w_emit) begin
            r_char <= {b2da_pkg::ASCII_ZERO_HI, w_top};
            r_last <= w_is_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

endmodule

/* sv/binary_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary value to decimal ascii digits, most
// significant first, leading zeros suppressed, last digit flagged.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------------
//  input   | i_valid  | o_stall  | i_value
//  output  | o_valid  | i_stall  | o_digit_char, o_last_digit
//
//  conversion shifts one bit per cycle through the double dabble shift
//  register; the emitter then steps through all DIGITS digits of each value,
//  one digit per cycle unless the output stalls, skipped leading zeros included.
//  the emitter works on one value while the converter takes the next, so
//  a new value is taken once the previous result is handed to the emitter.
//  output stalls hold the emitter, and then the converter once its result
//  waits. reset is synchronous, active low, empties both.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [b2da_pkg::VALUE_BITS-1:0]    i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        o_digit_char,
    output logic                               o_last_digit
);

    b2da_pkg::t_bcd_xfer w_xfer;
    logic                w_xfer_take;

    b2da_dabble u_dabble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_xfer      (w_xfer),
        .i_xfer_take (w_xfer_take)
    );

    b2da_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_xfer       (w_xfer),
        .o_xfer_take  (w_xfer_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

/* sv/b2da_checker.sv */
// ----------------------------------------------------------------------------
// b2da_props
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b2da_props (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [b2da_pkg::VALUE_BITS-1:0]    i_value,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [b2da_pkg::CHAR_W-1:0]        o_digit_char,
    input logic                               o_last_digit
);

    // a stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_char)
                               && $stable(o_last_digit))
        else $error("output transaction changed while stalled");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= b2da_pkg::CHAR_W'(48))
                    && (o_digit_char <= b2da_pkg::CHAR_W'(57)))
        else $error("output character is not a decimal digit");

    // the converter raises o_stall after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after a transaction");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not empty after reset");

endmodule

bind binary_to_decimal_ascii_top b2da_props u_b2da_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_value      (i_value),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digit_char (o_digit_char),
    .o_last_digit (o_last_digit)
);
